FILE: rtl/core/single_float_chop_arith_unit_assert.svh
// assertion macros for the chopped single-precision arithmetic unit
// expects clk and rst in the scope of every use
`ifndef SINGLE_FLOAT_CHOP_ARITH_UNIT_ASSERT_SVH
`define SINGLE_FLOAT_CHOP_ARITH_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SFCA_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("sfca assertion failed");
`define SFCA_ASSERT_RST(lbl, expr) \
  lbl: assert property (@(posedge clk) (expr)) \
    else $error("sfca assertion failed");
`else
`define SFCA_ASSERT(lbl, expr)
`define SFCA_ASSERT_RST(lbl, expr)
`endif
`endif

FILE: rtl/core/sfca_pkg.sv
// shared types and constants of the chopped single-precision arithmetic unit
// no dependencies
package sfca_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam int unsigned MAG_W  = 51;
  localparam int unsigned DIV_W  = 25;
  localparam int unsigned EXPO_W = 11;
  localparam int unsigned NUM_CELLS = 25;

  localparam logic [31:0] MAX_MAG  = 32'h7f7fffff;
  localparam logic [31:0] SIGN_BIT = 32'h80000000;

  typedef struct packed {
    logic                     is_div;
    logic                     sat;
    logic                     sign;
    logic [MAG_W-1:0]         mag;
    logic signed [EXPO_W-1:0] expo;
    logic [DIV_W-1:0]         rem;
    logic [23:0]              dvsr;
    logic [DIV_W-1:0]         quo;
  } chain_t;

endpackage

FILE: rtl/core/single_float_chop_arith_unit.sv
// one transaction per cycle while the output register is empty or being taken
// two front stages, a row of 25 division cells that every transaction walks through,
// then two packing stages; the last one is the output register
// the whole row advances when the output register is empty or being taken
// synchronous reset clears all valid bits; no other state
`include "single_float_chop_arith_unit_assert.svh"
module single_float_chop_arith_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_bits
);

  logic en;
  logic             cv [sfca_pkg::NUM_CELLS+1];
  sfca_pkg::chain_t cd [sfca_pkg::NUM_CELLS+1];
  logic             tv;
  sfca_pkg::chain_t td;

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign tv = cv[sfca_pkg::NUM_CELLS];
  assign td = cd[sfca_pkg::NUM_CELLS];

  sfca_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .operation (operation),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (cv[0]),
    .out_data  (cd[0])
  );

  for (genvar g = 0; g < sfca_pkg::NUM_CELLS; g++) begin : g_cell
    sfca_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cv[g]),
      .in_data   (cd[g]),
      .out_valid (cv[g+1]),
      .out_data  (cd[g+1])
    );
  end

  sfca_pack u_pack (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (tv),
    .in_data     (td),
    .out_valid   (out_valid),
    .result_bits (result_bits)
  );

  `SFCA_ASSERT(a_no_inf_nan, !out_valid || (result_bits[30:23] != 8'hff))
  `SFCA_ASSERT_RST(a_reset_clears, !$past(rst) || !out_valid)
  `SFCA_ASSERT(a_div_rem_bound, !tv || !td.is_div || td.sat || (td.rem < {td.dvsr, 1'b0}))

endmodule

FILE: rtl/core/sfca_front.sv
// operand unpack, alignment, multiply, add and division setup stages (two register stages)
// depends on sfca_pkg
module sfca_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [1:0]           operation,
  input  logic [31:0]          operand_a,
  input  logic [31:0]          operand_b,
  output logic                 out_valid,
  output sfca_pkg::chain_t     out_data
);

  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        sb_eff, swap;
  logic        s_hi_c, s_lo_c;
  logic [7:0]  e_hi_c, e_lo_c, d;
  logic [23:0] m_hi_c, m_lo_c;
  logic [5:0]  dc;
  logic [49:0] lesser, shifted_c;

  // stage 0 registers
  logic        v0;
  logic [1:0]  op0;
  logic        s_hi, s_lo, eff_sub, both_zero, sx, bexp_zero, lost;
  logic [7:0]  e_hi, ea0, eb0;
  logic [23:0] m_hi, ma0, mb0;
  logic [49:0] shifted;
  logic [47:0] product;

  logic [50:0] sum;
  sfca_pkg::chain_t s1_next;

  always_comb begin
    ea = (operand_a[30:23] == 8'd0) ? 8'd1 : (operand_a[30:23] == 8'hff) ? 8'd254
         : operand_a[30:23];
    eb = (operand_b[30:23] == 8'd0) ? 8'd1 : (operand_b[30:23] == 8'hff) ? 8'd254
         : operand_b[30:23];
    ma = (operand_a[30:23] == 8'd0) ? 24'd0 : (operand_a[30:23] == 8'hff) ? 24'hffffff
         : {1'b1, operand_a[22:0]};
    mb = (operand_b[30:23] == 8'd0) ? 24'd0 : (operand_b[30:23] == 8'hff) ? 24'hffffff
         : {1'b1, operand_b[22:0]};
    sb_eff = operand_b[31] ^ (operation == sfca_pkg::OP_SUB);
    swap = (eb > ea) || ((eb == ea) && (mb > ma));
    s_hi_c = swap ? sb_eff : operand_a[31];
    s_lo_c = swap ? operand_a[31] : sb_eff;
    e_hi_c = swap ? eb : ea;
    e_lo_c = swap ? ea : eb;
    m_hi_c = swap ? mb : ma;
    m_lo_c = swap ? ma : mb;
    d = e_hi_c - e_lo_c;
    dc = (d > 8'd63) ? 6'd63 : d[5:0];
    lesser = {m_lo_c, 26'd0};
    shifted_c = lesser >> dc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0       <= operation;
      s_hi      <= s_hi_c;
      s_lo      <= s_lo_c;
      eff_sub   <= s_hi_c ^ s_lo_c;
      both_zero <= (ma == 24'd0) && (mb == 24'd0);
      sx        <= operand_a[31] ^ operand_b[31];
      bexp_zero <= (operand_b[30:23] == 8'd0);
      lost      <= ((shifted_c << dc) != lesser);
      e_hi      <= e_hi_c;
      ea0       <= ea;
      eb0       <= eb;
      m_hi      <= m_hi_c;
      ma0       <= ma;
      mb0       <= mb;
      shifted   <= shifted_c;
      product   <= ma * mb;
    end
  end

  always_comb begin
    if (eff_sub) begin
      sum = {1'b0, m_hi, 26'd0} - {1'b0, shifted} - {50'd0, lost};
    end else begin
      sum = {1'b0, m_hi, 26'd0} + {1'b0, shifted};
    end
    s1_next = '0;
    unique case (op0)
      sfca_pkg::OP_ADD, sfca_pkg::OP_SUB: begin
        s1_next.sign = both_zero ? (s_hi & s_lo) : ((sum == 51'd0) ? 1'b0 : s_hi);
        s1_next.mag  = sum;
        s1_next.expo = $signed({3'b0, e_hi}) - 11'sd176;
      end
      sfca_pkg::OP_MUL: begin
        s1_next.sign = sx;
        s1_next.mag  = {3'b0, product};
        s1_next.expo = $signed({3'b0, ea0}) + $signed({3'b0, eb0}) - 11'sd300;
      end
      sfca_pkg::OP_DIV: begin
        s1_next.is_div = 1'b1;
        s1_next.sat    = bexp_zero;
        s1_next.sign   = sx;
        s1_next.rem    = {1'b0, ma0};
        s1_next.dvsr   = mb0;
        s1_next.expo   = $signed({3'b0, ea0}) - $signed({3'b0, eb0}) - 11'sd24;
      end
      default: begin
        s1_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= s1_next;
    end
  end

endmodule

FILE: rtl/core/sfca_div_cell.sv
// one restoring-division cell: yields one quotient bit and passes the transaction on
// depends on sfca_pkg
module sfca_div_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  sfca_pkg::chain_t     in_data,
  output logic                 out_valid,
  output sfca_pkg::chain_t     out_data
);

  logic        ge;
  logic [24:0] diff;
  sfca_pkg::chain_t nxt;

  always_comb begin
    ge = in_data.rem >= {1'b0, in_data.dvsr};
    diff = in_data.rem - (ge ? {1'b0, in_data.dvsr} : 25'd0);
    nxt = in_data;
    nxt.rem = {diff[23:0], 1'b0};
    nxt.quo = {in_data.quo[23:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule

FILE: rtl/core/sfca_pack.sv
// leading-one search and result packing with flush and saturation (two stages)
// depends on sfca_pkg
module sfca_pack (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  sfca_pkg::chain_t     in_data,
  output logic                 out_valid,
  output logic [31:0]          result_bits
);

  logic [50:0] r_c;
  logic [5:0]  p_c;

  logic                     va;
  logic                     sat, sign, zero;
  logic [50:0]              r;
  logic [5:0]               p;
  logic signed [10:0]       expo;

  logic signed [11:0] ex;
  logic [50:0]        rn;
  logic [31:0]        res_c;

  always_comb begin
    r_c = in_data.is_div ? {26'd0, in_data.quo} : in_data.mag;
    p_c = 6'd0;
    for (int i = 0; i < 51; i++) begin
      if (r_c[i]) begin
        p_c = 6'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat  <= in_data.sat;
      sign <= in_data.sign;
      zero <= (r_c == 51'd0);
      r    <= r_c;
      p    <= p_c;
      expo <= in_data.expo;
    end
  end

  always_comb begin
    ex = $signed({6'b0, p}) + 12'(expo) + 12'sd127;
    rn = r << (6'd50 - p);
    if (sat || (!zero && ex >= 12'sd255)) begin
      res_c = (sign ? sfca_pkg::SIGN_BIT : 32'd0) | sfca_pkg::MAX_MAG;
    end else if (zero || ex <= 12'sd0) begin
      res_c = sign ? sfca_pkg::SIGN_BIT : 32'd0;
    end else begin
      res_c = {sign, ex[7:0], rn[49:27]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_bits <= res_c;
    end
  end

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the chopped single-precision arithmetic unit
// drives directed and random transactions, predicts each result in place, checks in order
// depends on sfca_pkg and single_float_chop_arith_unit
module testbench;

  localparam int NUM_RANDOM = 1100;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    bit          known;
    logic [31:0] want;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = sfca_pkg::OP_ADD;
  logic [31:0] operand_a = '0;
  logic [31:0] operand_b = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] result_bits;

  logic [31:0] pending_results[$];
  int          mismatches = 0;
  int          num_sent = 0;
  int          num_checked = 0;
  int          op_count[4] = '{0, 0, 0, 0};
  bit          idle_in = 1'b1;
  bit          idle_out = 1'b1;
  bit          hold_request = 1'b0;
  bit          in_fire;
  bit          out_fire;
  int          quiet_cycles = 0;

  single_float_chop_arith_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_ready(out_ready), .result_bits(result_bits)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %08h expected %08h", what, got, want);
    mismatches++;
  endtask

  // value = r * 2^q, chopped to a single pattern
  function automatic logic [31:0] chop_pack(logic s, logic [63:0] r, int q);
    int p;
    int ex;
    logic [63:0] mant;
    if (r == 0) return {s, 31'b0};
    p = 63;
    while (!r[p]) p--;
    ex = p + q + 127;
    if (ex >= 255) return {s, sfca_pkg::MAX_MAG[30:0]};
    if (ex <= 0) return {s, 31'b0};
    mant = (p >= 23) ? (r >> (p - 23)) : (r << (23 - p));
    return {s, ex[7:0], mant[22:0]};
  endfunction

  function automatic void unpack_operand(logic [31:0] x, output logic s, output int e,
                                         output logic [63:0] m);
    s = x[31];
    if (x[30:23] == 8'h00) begin
      e = 1;
      m = 0;
    end else if (x[30:23] == 8'hff) begin
      e = 254;
      m = 64'hffffff;
    end else begin
      e = int'(x[30:23]);
      m = {40'b0, 1'b1, x[22:0]};
    end
  endfunction

  function automatic logic [31:0] chop_sum(logic sa, int ea, logic [63:0] ma,
                                           logic sb, int eb, logic [63:0] mb);
    logic ts;
    int te;
    int d;
    logic [63:0] tm;
    logic [63:0] big;
    logic [63:0] lesser;
    logic [63:0] shifted;
    logic [63:0] r;
    bit lost;
    if (ma == 0 && mb == 0) return (sa & sb) ? sfca_pkg::SIGN_BIT : 32'h0;
    if (eb > ea || (eb == ea && mb > ma)) begin
      ts = sa; te = ea; tm = ma;
      sa = sb; ea = eb; ma = mb;
      sb = ts; eb = te; mb = tm;
    end
    if (mb == 0) return chop_pack(sa, ma, ea - 150);
    d = ea - eb;
    big = ma << 26;
    lesser = mb << 26;
    if (d >= 63) begin
      shifted = 0;
      lost = lesser != 0;
    end else begin
      shifted = lesser >> d;
      lost = (lesser & ((64'd1 << d) - 64'd1)) != 0;
    end
    if (sa == sb) r = big + shifted;
    else r = big - shifted - (lost ? 64'd1 : 64'd0);
    if (r == 0) return 32'h0;
    return chop_pack(sa, r, ea - 150 - 26);
  endfunction

  function automatic logic [31:0] chop_result(logic [1:0] op, logic [31:0] a, logic [31:0] b);
    logic sa;
    logic sb;
    logic s;
    int ea;
    int eb;
    logic [63:0] ma;
    logic [63:0] mb;
    unpack_operand(a, sa, ea, ma);
    unpack_operand(b, sb, eb, mb);
    s = sa ^ sb;
    case (op)
      sfca_pkg::OP_ADD: return chop_sum(sa, ea, ma, sb, eb, mb);
      sfca_pkg::OP_SUB: return chop_sum(sa, ea, ma, ~sb, eb, mb);
      sfca_pkg::OP_MUL: begin
        if (ma == 0 || mb == 0) return {s, 31'b0};
        return chop_pack(s, ma * mb, (ea - 150) + (eb - 150));
      end
      default: begin
        if (b[30:23] == 8'h00) return {s, sfca_pkg::MAX_MAG[30:0]};
        if (ma == 0) return {s, 31'b0};
        return chop_pack(s, (ma << 40) / mb, ea - eb - 40);
      end
    endcase
  endfunction

  function automatic logic [31:0] random_operand(logic [31:0] near);
    logic [31:0] x;
    x = $urandom;
    case ($urandom_range(0, 9))
      0: x[30:23] = 8'h00;
      1: x[30:23] = 8'hff;
      2: x[30:0] = $urandom_range(0, 1) ? 31'h0 : sfca_pkg::MAX_MAG[30:0];
      3: x[30:23] = $urandom_range(0, 1) ? 8'h01 : 8'hfe;
      4, 5: x[30:23] = 8'(near[30:23] + $urandom_range(0, 4) - 2);
      6: x[30:0] = near[30:0] ^ (31'd1 << $urandom_range(0, 22));
      default: ;
    endcase
    return x;
  endfunction

  task automatic send_txn(logic [1:0] op, logic [31:0] a, logic [31:0] b);
    int gap;
    gap = idle_in ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    operand_a <= a;
    operand_b <= b;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pending_results.push_back(chop_result(op, a, b));
    num_sent++;
    op_count[op]++;
  endtask

  // receiver
  initial begin
    int gap;
    logic [31:0] got;
    logic [31:0] want;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        gap = idle_out ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      got = result_bits;
      @(posedge clk);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", got, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) report_mismatch("result_bits", got, want);
        num_checked++;
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(negedge clk) begin
    in_fire = in_valid && in_ready;
    out_fire = out_valid && out_ready;
  end

  always @(posedge clk) begin
    if (rst || in_fire || out_fire) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d transactions outstanding", pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    vector_t table_rows[$];
    logic [1:0] op;
    logic [31:0] a;
    logic [31:0] b;
    table_rows = '{
      '{sfca_pkg::OP_ADD, 32'h00000000, 32'h00000000, 1, 32'h00000000},
      '{sfca_pkg::OP_ADD, 32'h80000000, 32'h80000000, 1, 32'h80000000},
      '{sfca_pkg::OP_SUB, 32'h80000000, 32'h00000000, 1, 32'h80000000},
      '{sfca_pkg::OP_SUB, 32'h3f800000, 32'h3f800000, 1, 32'h00000000},
      '{sfca_pkg::OP_ADD, 32'h3f800000, 32'h3f800000, 1, 32'h40000000},
      '{sfca_pkg::OP_ADD, 32'h00000001, 32'h3f800000, 1, 32'h3f800000},
      '{sfca_pkg::OP_ADD, 32'h3f800000, 32'h30800000, 1, 32'h3f800000},
      '{sfca_pkg::OP_SUB, 32'h3f800000, 32'h00800000, 1, 32'h3f7fffff},
      '{sfca_pkg::OP_SUB, 32'hffffffff, 32'h7fffffff, 1, 32'hff7fffff},
      '{sfca_pkg::OP_ADD, 32'h7f800000, 32'h3f800000, 0, 32'h0},
      '{sfca_pkg::OP_SUB, 32'h00800000, 32'h00800001, 0, 32'h0},
      '{sfca_pkg::OP_MUL, 32'h7f7fffff, 32'h40000000, 1, 32'h7f7fffff},
      '{sfca_pkg::OP_MUL, 32'h7fc00000, 32'h3f800000, 1, 32'h7f7fffff},
      '{sfca_pkg::OP_MUL, 32'h3fc00000, 32'h3fc00000, 1, 32'h40100000},
      '{sfca_pkg::OP_MUL, 32'h00800000, 32'h00800000, 1, 32'h00000000},
      '{sfca_pkg::OP_MUL, 32'h80800000, 32'h00800000, 1, 32'h80000000},
      '{sfca_pkg::OP_MUL, 32'h80000000, 32'h7f7fffff, 1, 32'h80000000},
      '{sfca_pkg::OP_DIV, 32'h3f800000, 32'h00000000, 1, 32'h7f7fffff},
      '{sfca_pkg::OP_DIV, 32'hbf800000, 32'h00000001, 1, 32'hff7fffff},
      '{sfca_pkg::OP_DIV, 32'h00000000, 32'h80000000, 1, 32'hff7fffff},
      '{sfca_pkg::OP_DIV, 32'h00000000, 32'h3f800000, 1, 32'h00000000},
      '{sfca_pkg::OP_DIV, 32'h80000000, 32'h3f800000, 1, 32'h80000000},
      '{sfca_pkg::OP_DIV, 32'h3f800000, 32'h40400000, 0, 32'h0},
      '{sfca_pkg::OP_DIV, 32'h00800000, 32'h7f7fffff, 0, 32'h0},
      '{sfca_pkg::OP_DIV, 32'h7f7fffff, 32'h00800000, 1, 32'h7f7fffff}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_rows[i]) begin
      if (table_rows[i].known &&
          chop_result(table_rows[i].op, table_rows[i].a, table_rows[i].b) !==
          table_rows[i].want)
        report_mismatch($sformatf("directed row %0d prediction", i),
                        chop_result(table_rows[i].op, table_rows[i].a, table_rows[i].b),
                        table_rows[i].want);
      send_txn(table_rows[i].op, table_rows[i].a, table_rows[i].b);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 100 == 0) begin
        idle_in = $urandom_range(0, 2) != 0;
        idle_out = $urandom_range(0, 2) != 0;
      end
      if (n == 300) hold_request = 1'b1;
      if (n == 700) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      op = 2'($urandom_range(0, 3));
      a = random_operand($urandom);
      b = random_operand(a);
      send_txn(op, a, b);
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d transactions (add %0d, sub %0d, mul %0d, div %0d), %0d checked",
             num_sent, op_count[sfca_pkg::OP_ADD], op_count[sfca_pkg::OP_SUB],
             op_count[sfca_pkg::OP_MUL], op_count[sfca_pkg::OP_DIV], num_checked);
    $display("with random stalls on both sides, one long output hold and one full drain");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/sfca_pkg.sv
rtl/core/sfca_front.sv
rtl/core/sfca_div_cell.sv
rtl/core/sfca_pack.sv
rtl/core/single_float_chop_arith_unit.sv
dv/testbench.sv
